>>> hw/rtl/png_scanline_unfilter_unit_defines.svh
// Assertion macros shared by the scanline unfilter RTL
`ifndef PNG_SCANLINE_UNFILTER_UNIT_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_UNIT_DEFINES_SVH

// same-cycle implication
`define PNGSU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PNGSU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pngsu_pkg.sv
// Shared types and constants of the scanline unfilter
package pngsu_pkg;

    localparam int BYTE_W      = 8;
    localparam int ROW_LEN_W   = 14;
    localparam int PIX_BYTES_W = 4;
    localparam int FILTER_W    = 3;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [BYTE_W-1:0] LAST_FILTER = 8'd4;

    localparam logic REG_ROW_LENGTH  = 1'b0;
    localparam logic REG_PIXEL_BYTES = 1'b1;

    typedef enum logic [FILTER_W-1:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    typedef enum logic [1:0] {
        KIND_FILTER,
        KIND_DATA,
        KIND_ERROR
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        t_filter           filter;
        logic              b_zero;
        logic              row_end;
        logic [BYTE_W-1:0] raw;
    } t_s1_item;

endpackage

>>> hw/rtl/pngsu_in_if.sv
// Input beat channel: raw scanline byte and start-of-pass mark
interface pngsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       start_of_pass;

    modport source (output valid, output raw_byte, output start_of_pass, input ready);
    modport sink   (input valid, input raw_byte, input start_of_pass, output ready);
endinterface

>>> hw/rtl/pngsu_out_if.sv
// Output beat channel: reconstructed byte with row end and error flags
interface pngsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter;

    modport source (output valid, output pixel_byte, output row_end, output bad_filter,
                    input ready);
    modport sink   (input valid, input pixel_byte, input row_end, input bad_filter,
                    output ready);
endinterface

>>> hw/rtl/pngsu_ram.sv
// Generic single-write, single-read RAM with registered read data
module pngsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/pngsu_front.sv
// Row sequencer: filter byte decode, position tracking, line store read, stage register
`include "png_scanline_unfilter_unit_defines.svh"

module pngsu_front #(
    parameter int MAX_ROW_BYTES = 8192
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pngsu_in_if.sink                      i_in,
    input  logic [pngsu_pkg::ROW_LEN_W-1:0] i_row_length,
    output logic                          o_s1_valid,
    output pngsu_pkg::t_s1_item           o_s1_item,
    output logic [(MAX_ROW_BYTES > 1 ? $clog2(MAX_ROW_BYTES) : 1)-1:0] o_s1_col,
    input  logic                          i_s1_ready,
    output logic                          o_rd_en,
    output logic [(MAX_ROW_BYTES > 1 ? $clog2(MAX_ROW_BYTES) : 1)-1:0] o_rd_addr
);

    localparam int AW    = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int LW0   = $clog2(MAX_ROW_BYTES + 1);
    localparam int LEN_W = (pngsu_pkg::ROW_LEN_W > LW0) ? pngsu_pkg::ROW_LEN_W : LW0;

    logic                  r_first,    n_first;
    logic                  r_failed,   n_failed;
    logic                  r_expect,   n_expect;
    logic [AW-1:0]         r_col,      n_col;
    pngsu_pkg::t_filter    r_filter,   n_filter;
    logic                  r_s1_valid, n_s1_valid;
    pngsu_pkg::t_s1_item   r_s1_item,  n_s1_item;
    logic [AW-1:0]         r_s1_col,   n_s1_col;

    logic                  accept;
    logic                  row_last;
    logic [LEN_W-1:0]      len_eff;

    assign i_in.ready = !r_s1_valid || i_s1_ready;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        if (i_row_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (LEN_W'(i_row_length) > LEN_W'(MAX_ROW_BYTES)) begin
            len_eff = LEN_W'(MAX_ROW_BYTES);
        end else begin
            len_eff = LEN_W'(i_row_length);
        end
    end

    assign row_last = (LEN_W'(r_col) + LEN_W'(1)) >= len_eff;

    always_comb begin
        n_first    = r_first;
        n_failed   = r_failed;
        n_expect   = r_expect;
        n_col      = r_col;
        n_filter   = r_filter;
        n_s1_valid = r_s1_valid && !i_s1_ready;
        n_s1_item  = r_s1_item;
        n_s1_col   = r_s1_col;
        if (accept) begin
            if (i_in.start_of_pass) begin
                n_first  = 1'b1;
                n_failed = 1'b0;
                n_expect = 1'b1;
            end
            if (!n_failed) begin
                n_s1_valid        = 1'b1;
                n_s1_col          = r_col;
                n_s1_item.raw     = i_in.raw_byte;
                n_s1_item.filter  = r_filter;
                n_s1_item.b_zero  = n_first;
                n_s1_item.row_end = 1'b0;
                if (n_expect) begin
                    if (i_in.raw_byte > pngsu_pkg::LAST_FILTER) begin
                        n_s1_item.kind = pngsu_pkg::KIND_ERROR;
                        n_failed       = 1'b1;
                    end else begin
                        n_s1_item.kind = pngsu_pkg::KIND_FILTER;
                        n_filter       = pngsu_pkg::t_filter'(i_in.raw_byte[2:0]);
                        n_expect       = 1'b0;
                        n_col          = '0;
                    end
                end else begin
                    n_s1_item.kind    = pngsu_pkg::KIND_DATA;
                    n_s1_item.row_end = row_last;
                    if (row_last) begin
                        n_expect = 1'b1;
                        n_first  = 1'b0;
                    end else begin
                        n_col = r_col + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= 1'b1;
            r_failed   <= 1'b0;
            r_expect   <= 1'b1;
            r_col      <= '0;
            r_filter   <= pngsu_pkg::FILT_NONE;
            r_s1_valid <= 1'b0;
        end else begin
            r_first    <= n_first;
            r_failed   <= n_failed;
            r_expect   <= n_expect;
            r_col      <= n_col;
            r_filter   <= n_filter;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_item <= n_s1_item;
        r_s1_col  <= n_s1_col;
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_item  = r_s1_item;
    assign o_s1_col   = r_s1_col;
    assign o_rd_en    = accept;
    assign o_rd_addr  = r_col;

    `PNGSU_ASSERT_NXT(a_drop_after_fail, i_clk, i_rst_n,
        accept && r_failed && !i_in.start_of_pass, !r_s1_valid,
        "byte entered the pipeline after a filter error")
    `PNGSU_ASSERT_NXT(a_error_sets_failed, i_clk, i_rst_n,
        accept && n_s1_valid && (n_s1_item.kind == pngsu_pkg::KIND_ERROR), r_failed,
        "filter error did not latch the failed state")
    `PNGSU_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n,
        !r_s1_valid, i_in.ready,
        "input not ready with an empty stage register")

endmodule

>>> hw/rtl/pngsu_recon.sv
// Reconstruction stage: predictor, byte sum, neighbor histories, output register
`include "png_scanline_unfilter_unit_defines.svh"

module pngsu_recon #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [pngsu_pkg::PIX_BYTES_W-1:0] i_pixel_bytes,
    input  logic                            i_s1_valid,
    input  pngsu_pkg::t_s1_item             i_s1_item,
    input  logic [(MAX_ROW_BYTES > 1 ? $clog2(MAX_ROW_BYTES) : 1)-1:0] i_s1_col,
    output logic                            o_s1_ready,
    input  logic [pngsu_pkg::BYTE_W-1:0]    i_ram_q,
    output logic                            o_wr_en,
    output logic [(MAX_ROW_BYTES > 1 ? $clog2(MAX_ROW_BYTES) : 1)-1:0] o_wr_addr,
    output logic [pngsu_pkg::BYTE_W-1:0]    o_wr_data,
    pngsu_out_if.source                     o_out
);

    localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic [7:0] r_left [MAX_PIXEL_BYTES];
    logic [7:0] r_ul   [MAX_PIXEL_BYTES];
    logic       r_out_valid;
    logic [7:0] r_out_pixel;
    logic       r_out_row_end;
    logic       r_out_bad;

    logic [pngsu_pkg::PIX_BYTES_W-1:0] pb_eff;
    logic [HW-1:0] hidx;
    logic [7:0]    a_byte, b_byte, c_byte, pred, val;
    logic [8:0]    avg_sum;
    logic          out_free, s1_retire, is_data, is_filter;

    function automatic logic [9:0] abs10(input logic signed [9:0] d);
        abs10 = d[9] ? 10'(-d) : 10'(d);
    endfunction

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] ds_a, ds_b, ds_c;
        logic [9:0]        pa, pb, pc;
        ds_a = $signed({2'b00, b}) - $signed({2'b00, c});
        ds_b = $signed({2'b00, a}) - $signed({2'b00, c});
        ds_c = ds_a + ds_b;
        pa   = abs10(ds_a);
        pb   = abs10(ds_b);
        pc   = abs10(ds_c);
        if (pa <= pb && pa <= pc) begin
            paeth = a;
        end else if (pb <= pc) begin
            paeth = b;
        end else begin
            paeth = c;
        end
    endfunction

    always_comb begin
        if (i_pixel_bytes == '0) begin
            pb_eff = pngsu_pkg::PIX_BYTES_W'(1);
        end else if (32'(i_pixel_bytes) > 32'(MAX_PIXEL_BYTES)) begin
            pb_eff = pngsu_pkg::PIX_BYTES_W'(MAX_PIXEL_BYTES);
        end else begin
            pb_eff = i_pixel_bytes;
        end
    end

    assign hidx    = HW'(pb_eff - pngsu_pkg::PIX_BYTES_W'(1));
    assign a_byte  = r_left[hidx];
    assign c_byte  = r_ul[hidx];
    assign b_byte  = i_s1_item.b_zero ? 8'd0 : i_ram_q;
    assign avg_sum = {1'b0, a_byte} + {1'b0, b_byte};

    always_comb begin
        case (i_s1_item.filter)
            pngsu_pkg::FILT_NONE:  pred = 8'd0;
            pngsu_pkg::FILT_SUB:   pred = a_byte;
            pngsu_pkg::FILT_UP:    pred = b_byte;
            pngsu_pkg::FILT_AVG:   pred = avg_sum[8:1];
            pngsu_pkg::FILT_PAETH: pred = paeth(a_byte, b_byte, c_byte);
            default:               pred = 8'd0;
        endcase
    end

    assign val       = i_s1_item.raw + pred;
    assign is_data   = i_s1_item.kind == pngsu_pkg::KIND_DATA;
    assign is_filter = i_s1_item.kind == pngsu_pkg::KIND_FILTER;
    assign out_free  = !r_out_valid || o_out.ready;
    assign o_s1_ready = is_filter || out_free;
    assign s1_retire = i_s1_valid && o_s1_ready;

    assign o_wr_en   = s1_retire && is_data;
    assign o_wr_addr = i_s1_col;
    assign o_wr_data = val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                r_left[k] <= '0;
                r_ul[k]   <= '0;
            end
        end else if (s1_retire && is_filter) begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                r_left[k] <= '0;
                r_ul[k]   <= '0;
            end
        end else if (s1_retire && is_data) begin
            for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
                r_left[k] <= r_left[k-1];
                r_ul[k]   <= r_ul[k-1];
            end
            r_left[0] <= val;
            r_ul[0]   <= b_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_retire && !is_filter) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_retire && !is_filter) begin
            r_out_pixel   <= is_data ? val : 8'd0;
            r_out_row_end <= is_data && i_s1_item.row_end;
            r_out_bad     <= !is_data;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pixel_byte = r_out_pixel;
    assign o_out.row_end    = r_out_row_end;
    assign o_out.bad_filter = r_out_bad;

    `PNGSU_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n,
        s1_retire && !is_filter, r_out_valid,
        "retired beat did not reach the output register")
    `PNGSU_ASSERT_NXT(a_hist_cleared, i_clk, i_rst_n,
        s1_retire && is_filter, (r_left[0] == '0) && (r_ul[0] == '0),
        "neighbor history not cleared at filter byte")
    `PNGSU_ASSERT_IMP(a_bad_is_empty, i_clk, i_rst_n,
        r_out_valid && r_out_bad, (r_out_pixel == '0) && !r_out_row_end,
        "error beat carries data")

endmodule

>>> hw/rtl/png_scanline_unfilter_unit.sv
// PNG scanline unfilter: filter types none, sub, up, average and Paeth.
//
// Input channel i_in carries one beat per decompressed byte: raw_byte and
// start_of_pass, which marks the filter byte of a pass's first row. Output
// channel o_out carries one beat per reconstructed byte (pixel_byte, row_end
// on the last byte of a row) or a single beat with bad_filter set when a
// filter byte above 4 arrives; input is then dropped until the next
// start_of_pass. Filter bytes themselves give no output beat.
// The user must write row_length (address 0) and pixel_bytes (address 4) on
// the APB port only while the block is idle; the block does not enforce it.
// Throughput: one byte per cycle while the receiver does not stall. An
// accepted byte goes into the stage register, then into the output register;
// the line store read for the row above is issued at accept and is the only
// read per byte, alongside one write of the result.
// Reset clears row position, error state and histories and expects a filter
// byte; the line store needs no clearing. While the receiver stalls, one beat
// waits in the output register and one in the stage register; then i_in
// drops ready.
module png_scanline_unfilter_unit #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pngsu_in_if.sink                          i_in,
    pngsu_out_if.source                       o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pngsu_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pngsu_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pngsu_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

    logic [pngsu_pkg::ROW_LEN_W-1:0]   r_row_length;
    logic [pngsu_pkg::PIX_BYTES_W-1:0] r_pixel_bytes;
    logic                              cfg_wr;

    logic                s1_valid;
    logic                s1_ready;
    pngsu_pkg::t_s1_item s1_item;
    logic [AW-1:0]       s1_col;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [7:0]          ram_q;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [7:0]          wr_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length  <= pngsu_pkg::ROW_LEN_W'(1);
            r_pixel_bytes <= pngsu_pkg::PIX_BYTES_W'(1);
        end else if (cfg_wr) begin
            case (paddr[2])
                pngsu_pkg::REG_ROW_LENGTH:
                    r_row_length <= pwdata[pngsu_pkg::ROW_LEN_W-1:0];
                pngsu_pkg::REG_PIXEL_BYTES:
                    r_pixel_bytes <= pwdata[pngsu_pkg::PIX_BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            pngsu_pkg::REG_ROW_LENGTH:  prdata = pngsu_pkg::APB_DATA_W'(r_row_length);
            pngsu_pkg::REG_PIXEL_BYTES: prdata = pngsu_pkg::APB_DATA_W'(r_pixel_bytes);
            default:                    prdata = '0;
        endcase
    end

    pngsu_front #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_row_length(r_row_length),
        .o_s1_valid  (s1_valid),
        .o_s1_item   (s1_item),
        .o_s1_col    (s1_col),
        .i_s1_ready  (s1_ready),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr)
    );

    pngsu_ram #(
        .WIDTH(pngsu_pkg::BYTE_W),
        .DEPTH(MAX_ROW_BYTES)
    ) u_line_store (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(ram_q)
    );

    pngsu_recon #(
        .MAX_ROW_BYTES  (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
    ) u_recon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pixel_bytes(r_pixel_bytes),
        .i_s1_valid   (s1_valid),
        .i_s1_item    (s1_item),
        .i_s1_col     (s1_col),
        .o_s1_ready   (s1_ready),
        .i_ram_q      (ram_q),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_out        (o_out)
    );

endmodule
